### design/vebset_pkg.sv
// Package: shared types, constants and search helpers of the ordered integer set.
package vebset_pkg;

	localparam int KEY_W = 16;
	localparam int OUT_W = 17;
	localparam int LEAF_WORDS = 1024;
	localparam int SUM_WORDS = 16;

	typedef enum logic [2:0] {
		FN_INSERT = 3'd0,
		FN_DELETE = 3'd1,
		FN_MEMBER = 3'd2,
		FN_SUCC   = 3'd3,
		FN_PRED   = 3'd4
	} func_t;

	// classified command handed from front to back
	typedef struct packed {
		logic [2:0]       func;
		logic [KEY_W-1:0] key;
	} cmd_t;

	// lowest set bit at or above a position, 64-bit word
	function automatic logic [6:0] low_from(input logic [63:0] m, input logic [6:0] q);
		logic [6:0] r;
		r = 7'd64;
		for (int i = 63; i >= 0; i--) begin
			if (m[i] && (7'(i) >= q)) r = 7'(i);
		end
		return r;
	endfunction

	// highest set bit at or below a position (q may be -1 as 8'hff)
	function automatic logic [6:0] high_to(input logic [63:0] m, input logic signed [7:0] q);
		logic [6:0] r;
		r = 7'd64;
		for (int i = 0; i < 64; i++) begin
			if (m[i] && (8'(i) <= q) && !q[7]) r = 7'(i);
		end
		return r;
	endfunction

endpackage

### design/vebset_front.sv
// Front part: two-entry command queue that registers the incoming commands.
module vebset_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [2:0]                  func,
	input  logic [vebset_pkg::KEY_W-1:0] key,
	output logic                        cmd_valid,
	input  logic                        cmd_take,
	output vebset_pkg::cmd_t            cmd
);
	vebset_pkg::cmd_t mem_q [2];
	logic             wp_q, rp_q;
	logic [1:0]       cnt_q;
	logic             push;

	assign in_stall  = (cnt_q == 2'd2);
	assign push      = in_valid && !in_stall;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = mem_q[rp_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= '{func: func, key: key};
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (cmd_take) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(cmd_take);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n) cmd_take |-> cmd_valid)
		else $error("take from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !cmd_take) |=> cnt_q == $past(cnt_q) + 2'd1)
		else $error("fill count slip");
endmodule

### design/vebset_back.sv
// Back part: bitmap memories and the sequencer that executes one command.
module vebset_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	output logic                           cmd_take,
	input  vebset_pkg::cmd_t               cmd,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           hit,
	output logic [vebset_pkg::OUT_W-1:0]   answer,
	output logic [vebset_pkg::OUT_W-1:0]   count,
	output logic [vebset_pkg::OUT_W-1:0]   smallest,
	output logic [vebset_pkg::OUT_W-1:0]   largest
);
	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_LEAF, ST_UPD, ST_SUMR, ST_SUMQ, ST_LEAFR, ST_LEAFQ,
		ST_DONE
	} state_t;

	state_t           st_q;
	logic [63:0]      leaf_mem [vebset_pkg::LEAF_WORDS];
	logic [63:0]      sum_q    [vebset_pkg::SUM_WORDS];
	logic [15:0]      top_q;
	logic [9:0]       clr_q;
	logic [2:0]       func_q;
	logic [15:0]      key_q;
	logic [63:0]      rd_q;
	logic [9:0]       raddr;
	logic             rd_en;
	logic [9:0]       word_q;
	logic [16:0]      cnt_q, min_q, max_q, ans_q;
	logic             hit_q;
	logic             dir_q;  // 0 up, 1 down
	logic [1:0]       phase_q; // 0 answer, 1 min, 2 max
	logic [63:0]      wdata;
	logic             wen;
	logic [9:0]       waddr;

	// result of the summary search, registered
	logic        s_found_q;
	logic [9:0]  s_word_q;
	logic        lf_edge;

	// leaf memory, one read and one write port
	always_ff @(posedge clk) begin
		if (wen) leaf_mem[waddr] <= wdata;
		if (rd_en) rd_q <= leaf_mem[raddr];
	end

	logic [9:0]  w_k;
	logic [5:0]  b_k;
	logic [3:0]  s_k;
	logic [63:0] upd;
	logic        mem_b;
	assign w_k = key_q[15:6];
	assign b_k = key_q[5:0];
	assign s_k = w_k[9:6];
	assign mem_b = rd_q[b_k];
	always_comb begin
		upd = rd_q;
		upd[b_k] = (func_q == vebset_pkg::FN_INSERT);
	end

	// summary search: next/prev non-empty word at or beyond word_q in chosen direction
	logic [6:0]  sl;
	logic [4:0]  tl;
	logic        s_found;
	logic [9:0]  s_word;
	always_comb begin
		logic [63:0] sm;
		logic [6:0]  p;
		logic [15:0] tm;
		s_found = 1'b0; s_word = '0; tl = 5'd16;
		tm = top_q;
		sm = sum_q[word_q[9:6]];
		if (!dir_q) begin
			p = vebset_pkg::low_from(sm, {1'b0, word_q[5:0]});
			if (p != 7'd64) begin s_found = 1'b1; s_word = {word_q[9:6], p[5:0]}; end
			else begin
				for (int i = 15; i >= 0; i--) if (tm[i] && 5'(i) > {1'b0, word_q[9:6]}) tl = 5'(i);
				if (tl != 5'd16) begin
					p = vebset_pkg::low_from(sum_q[tl[3:0]], 7'd0);
					s_found = 1'b1; s_word = {tl[3:0], p[5:0]};
				end
			end
		end else begin
			p = vebset_pkg::high_to(sm, {2'b0, word_q[5:0]});
			if (p != 7'd64) begin s_found = 1'b1; s_word = {word_q[9:6], p[5:0]}; end
			else begin
				for (int i = 0; i < 16; i++) if (tm[i] && 5'(i) < {1'b0, word_q[9:6]}) tl = 5'(i);
				if (tl != 5'd16) begin
					p = vebset_pkg::high_to(sum_q[tl[3:0]], 8'sd63);
					s_found = 1'b1; s_word = {tl[3:0], p[5:0]};
				end
			end
		end
	end

	// first or last element of the leaf word found by the summary search
	assign sl = dir_q ? vebset_pkg::high_to(rd_q, 8'sd63) : vebset_pkg::low_from(rd_q, 7'd0);

	// search position within the first word
	logic [6:0]  lp;
	logic [16:0] srch_res;
	always_comb begin
		lp = 7'd64;
		if (phase_q == 2'd0) begin
			if (!dir_q) lp = (b_k == 6'd63) ? 7'd64 :
				vebset_pkg::low_from(rd_q, 7'(b_k) + 7'd1);
			else lp = vebset_pkg::high_to(rd_q, $signed({2'b0, b_k}) - 8'sd1);
		end else if (!dir_q) lp = vebset_pkg::low_from(rd_q, 7'd0);
		else lp = vebset_pkg::high_to(rd_q, 8'sd63);
		srch_res = {1'b0, word_q, lp[5:0]};
	end

	always_comb begin
		wen = 1'b0; waddr = w_k; wdata = upd; rd_en = 1'b0; raddr = w_k;
		if (st_q == ST_CLEAR) begin wen = 1'b1; waddr = clr_q; wdata = '0; end
		if (st_q == ST_UPD) wen = (func_q == vebset_pkg::FN_INSERT && !mem_b) ||
			(func_q == vebset_pkg::FN_DELETE && mem_b);
		if (st_q == ST_IDLE && cmd_valid) begin rd_en = 1'b1; raddr = cmd.key[15:6]; end
		if (st_q == ST_SUMQ) begin rd_en = 1'b1; raddr = s_word; end
	end

	assign cmd_take = (st_q == ST_IDLE) && cmd_valid;

	// sequencer: read word, update, then searches (answer for successor/predecessor only, min, max)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLEAR; clr_q <= '0; top_q <= '0; cnt_q <= '0;
			min_q <= '1; max_q <= '1; out_valid <= 1'b0;
			func_q <= '0; key_q <= '0; word_q <= '0; hit_q <= 1'b0; ans_q <= '1;
			dir_q <= 1'b0; phase_q <= '0;
			hit <= 1'b0; answer <= '1; count <= '0; smallest <= '1; largest <= '1;
			for (int i = 0; i < vebset_pkg::SUM_WORDS; i++) sum_q[i] <= '0;
		end else begin
			unique case (st_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 10'd1;
					if (clr_q == 10'(vebset_pkg::LEAF_WORDS - 1)) st_q <= ST_IDLE;
				end
				ST_IDLE: if (cmd_valid) begin
					func_q <= cmd.func; key_q <= cmd.key; st_q <= ST_LEAF;
				end
				ST_LEAF: begin
					hit_q <= 1'b0; ans_q <= '1; word_q <= w_k;
					st_q <= ST_UPD;
				end
				ST_UPD: begin
					if (func_q == vebset_pkg::FN_INSERT && !mem_b) begin
						hit_q <= 1'b1; cnt_q <= cnt_q + 17'd1;
						sum_q[s_k][w_k[5:0]] <= 1'b1; top_q[s_k] <= 1'b1;
					end else if (func_q == vebset_pkg::FN_DELETE && mem_b) begin
						hit_q <= 1'b1; cnt_q <= cnt_q - 17'd1;
						if (upd == '0) begin
							sum_q[s_k][w_k[5:0]] <= 1'b0;
							if ((sum_q[s_k] & ~(64'd1 << w_k[5:0])) == '0) top_q[s_k] <= 1'b0;
						end
					end else if (func_q == vebset_pkg::FN_MEMBER) hit_q <= mem_b;
					if (func_q == vebset_pkg::FN_SUCC) begin
						phase_q <= 2'd0; dir_q <= 1'b0; st_q <= ST_LEAFQ;
					end else if (func_q == vebset_pkg::FN_PRED) begin
						phase_q <= 2'd0; dir_q <= 1'b1; st_q <= ST_LEAFQ;
					end else begin
						phase_q <= 2'd1; dir_q <= 1'b0; word_q <= '0; st_q <= ST_SUMR;
					end
				end
				ST_LEAFQ: begin
					// rd_q holds word_q; search within it, else go to summary
					if (lp != 7'd64) begin
						if (phase_q == 2'd0) ans_q <= srch_res;
						else if (phase_q == 2'd1) min_q <= srch_res;
						else max_q <= srch_res;
						st_q <= (phase_q == 2'd2) ? ST_DONE : ST_SUMR;
						phase_q <= phase_q + 2'd1;
						dir_q <= (phase_q == 2'd1);
						word_q <= (phase_q == 2'd1) ? 10'h3ff : 10'h000;
					end else if ((!dir_q && word_q == 10'h3ff) || (dir_q && word_q == 10'h000)) begin
						// no word beyond the key: no answer, go on to the minimum
						ans_q <= '1; phase_q <= 2'd1; dir_q <= 1'b0; word_q <= '0;
						st_q <= ST_SUMR;
					end else begin
						// beyond the first word
						word_q <= dir_q ? word_q - 10'd1 : word_q + 10'd1;
						st_q <= ST_SUMQ;
					end
				end
				ST_SUMR: st_q <= ST_SUMQ;
				ST_SUMQ: st_q <= ST_LEAFR;
				ST_LEAFR: begin
					st_q <= (phase_q == 2'd2) ? ST_DONE : ST_SUMR;
					if (phase_q == 2'd0) ans_q <= s_found_q ? {1'b0, s_word_q, sl[5:0]} : '1;
					else if (phase_q == 2'd1) min_q <= s_found_q ? {1'b0, s_word_q, sl[5:0]} : '1;
					else max_q <= s_found_q ? {1'b0, s_word_q, sl[5:0]} : '1;
					dir_q <= (phase_q == 2'd1);
					word_q <= (phase_q == 2'd1) ? 10'h3ff : 10'h000;
					phase_q <= phase_q + 2'd1;
				end
				ST_DONE: if (!out_valid || !out_stall) begin
					out_valid <= 1'b1; hit <= hit_q; answer <= ans_q; count <= cnt_q;
					smallest <= min_q; largest <= max_q; st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
			if (out_valid && !out_stall && st_q != ST_DONE) out_valid <= 1'b0;
		end
	end

	// capture the summary search as the leaf word read is issued
	assign lf_edge = (st_q == ST_SUMQ);
	always_ff @(posedge clk) begin
		if (lf_edge) begin
			s_found_q <= s_found; s_word_q <= s_word;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |-> st_q == ST_IDLE) else $error("take while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_UPD && func_q == vebset_pkg::FN_INSERT && !mem_b)
		|=> cnt_q == $past(cnt_q) + 17'd1)
		else $error("count not incremented");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0 && st_q == ST_IDLE) |-> top_q == '0) else $error("empty set with summary bits");
endmodule

### design/ordered_integer_set_succ_pred.sv
// Top level: ordered integer set with member, successor and predecessor queries.
// channel | direction | handshake        | payload
// in      | input     | in_valid/in_stall | func, key
// out     | output    | out_valid/out_stall | hit, answer, count, smallest, largest
// An operation reads and updates the key word; a successor/predecessor then searches for its
// answer (in the key word or beyond it); every operation then searches for the minimum and
// maximum (summary lookup, leaf read) and finally loads the result.
// After reset a clearing pass zeroes all 1024 leaf words; up to two items wait queued.
// The two-entry queue keeps accepting, until it is full, while the back part waits on out_stall.
module ordered_integer_set_succ_pred (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  func,
	input  logic [15:0] key,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        hit,
	output logic [16:0] answer,
	output logic [16:0] count,
	output logic [16:0] smallest,
	output logic [16:0] largest
);
	logic             cmd_valid, cmd_take;
	vebset_pkg::cmd_t cmd;

	vebset_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .func, .key,
		.cmd_valid, .cmd_take, .cmd
	);

	vebset_back u_back (
		.clk, .arst_n, .cmd_valid, .cmd_take, .cmd,
		.out_valid, .out_stall, .hit, .answer, .count, .smallest, .largest
	);
endmodule

### tb/tb_ordered_integer_set_succ_pred.sv
// Testbench for the ordered integer set: directed and random operations checked against a local model.
module tb_ordered_integer_set_succ_pred;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT_CYCLES = 400000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  func;
	logic [15:0] key;
	logic        out_valid;
	logic        out_stall;
	logic        hit;
	logic [16:0] answer;
	logic [16:0] count;
	logic [16:0] smallest;
	logic [16:0] largest;

	typedef struct packed {
		logic        hit;
		logic [16:0] answer;
		logic [16:0] count;
		logic [16:0] smallest;
		logic [16:0] largest;
	} set_result_t;

	// local copy of the set, one bit per key
	bit          member_bits [0:65535];
	int          member_total;
	set_result_t result_fifo [$];
	int          mismatch_count;
	int          cycle_count;
	bit          hold_off;
	int          hold_cycles;

	ordered_integer_set_succ_pred u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.key       (key),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.hit       (hit),
		.answer    (answer),
		.count     (count),
		.smallest  (smallest),
		.largest   (largest)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// first member at or above lo, scanning up; -1 when none
	function automatic logic [16:0] scan_up(input int lo);
		for (int i = lo; i < 65536; i++)
			if (member_bits[i]) return 17'(i);
		return '1;
	endfunction

	function automatic logic [16:0] scan_down(input int hi);
		for (int i = hi; i >= 0; i--)
			if (member_bits[i]) return 17'(i);
		return '1;
	endfunction

	// apply one operation to the local set and queue the outcome
	function automatic void apply_op(input logic [2:0] f, input logic [15:0] k);
		set_result_t r;
		r.hit = 1'b0;
		r.answer = '1;
		case (f)
			vebset_pkg::FN_INSERT: begin
				if (!member_bits[k]) begin
					member_bits[k] = 1'b1;
					member_total++;
					r.hit = 1'b1;
				end
			end
			vebset_pkg::FN_DELETE: begin
				if (member_bits[k]) begin
					member_bits[k] = 1'b0;
					member_total--;
					r.hit = 1'b1;
				end
			end
			vebset_pkg::FN_MEMBER: r.hit = member_bits[k];
			vebset_pkg::FN_SUCC:   r.answer = scan_up(int'(k) + 1);
			vebset_pkg::FN_PRED:   r.answer = scan_down(int'(k) - 1);
			default: ;
		endcase
		r.count = 17'(member_total);
		r.smallest = scan_up(0);
		r.largest = scan_down(65535);
		result_fifo.push_back(r);
	endfunction

	// send one transfer after a random gap; valid stays high into a gapless next transfer
	task automatic send_op(input logic [2:0] f, input logic [15:0] k, input bit no_gap = 0);
		int gap;
		gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14));
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		key <= k;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		apply_op(f, k);
	endtask

	// receiver stall: random per transfer, or held during a hold-off
	initial begin
		int wait_cycles;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				out_stall <= 1'b1;
				repeat (hold_cycles) @(posedge clk);
				hold_off = 1'b0;
			end
			wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
			if (wait_cycles != 0) begin
				out_stall <= 1'b1;
				repeat (wait_cycles) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid || out_stall) @(posedge clk);
		end
	end

	// check each accepted result against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (result_fifo.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) $display("unexpected result transfer");
			end else begin
				set_result_t e;
				e = result_fifo.pop_front();
				if (e !== {hit, answer, count, smallest, largest}) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display({"mismatch: exp hit=%0b ans=%h cnt=%0d min=%h max=%h,",
							" got hit=%0b ans=%h cnt=%0d min=%h max=%h"},
							e.hit, e.answer, e.count, e.smallest, e.largest,
							hit, answer, count, smallest, largest);
				end
			end
		end
	end

	// cycle limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// empty set, extremes, strict successor/predecessor, unused codes
	task automatic test_directed();
		send_op(vebset_pkg::FN_SUCC, 16'd0);
		send_op(vebset_pkg::FN_PRED, 16'hFFFF);
		send_op(vebset_pkg::FN_MEMBER, 16'd0);
		send_op(vebset_pkg::FN_DELETE, 16'd5);
		send_op(vebset_pkg::FN_INSERT, 16'd0);
		send_op(vebset_pkg::FN_INSERT, 16'hFFFF);
		send_op(vebset_pkg::FN_INSERT, 16'hFFFF);
		send_op(vebset_pkg::FN_INSERT, 16'h1040);
		send_op(vebset_pkg::FN_SUCC, 16'd0);
		send_op(vebset_pkg::FN_PRED, 16'hFFFF);
		send_op(vebset_pkg::FN_SUCC, 16'hFFFF);
		send_op(vebset_pkg::FN_PRED, 16'd0);
		send_op(vebset_pkg::FN_SUCC, 16'h1040);
		send_op(vebset_pkg::FN_PRED, 16'h1040);
		send_op(vebset_pkg::FN_MEMBER, 16'h1040);
		send_op(3'd5, 16'h1234);
		send_op(3'd6, 16'hAAAA);
		send_op(3'd7, 16'h5555);
		send_op(vebset_pkg::FN_DELETE, 16'h1040);
		send_op(vebset_pkg::FN_DELETE, 16'h0000);
		send_op(vebset_pkg::FN_DELETE, 16'hFFFF);
		send_op(vebset_pkg::FN_PRED, 16'h8000);
	endtask

	// random mix, keys mostly in a small neighborhood so hits occur
	task automatic test_random(input int n);
		logic [15:0] k;
		logic [2:0] f;
		int base;
		base = $urandom_range(0, 65535);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0: k = 16'($urandom);
				1: k = ($urandom_range(0, 1)) ? 16'hFFFF : 16'h0000;
				default: k = 16'(base + $urandom_range(0, 300));
			endcase
			f = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
				: 3'($urandom_range(0, 4));
			if (i % 100 == 99) base = $urandom_range(0, 65535);
			send_op(f, k);
		end
	endtask

	// receiver holds off while back-to-back transfers fill the block
	task automatic test_backpressure();
		hold_cycles = 300;
		hold_off = 1'b1;
		for (int i = 0; i < 20; i++)
			send_op(3'($urandom_range(0, 4)), 16'($urandom_range(0, 40)), 1);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = '0;
		key = '0;
		mismatch_count = 0;
		cycle_count = 0;
		member_total = 0;
		hold_off = 1'b0;
		hold_cycles = 0;
		foreach (member_bits[i]) member_bits[i] = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_backpressure();
		test_random(420);
		in_valid <= 1'b0;
		while (result_fifo.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatch_count == 0 && result_fifo.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

### files.f
design/vebset_pkg.sv
design/vebset_front.sv
design/vebset_back.sv
design/ordered_integer_set_succ_pred.sv
tb/tb_ordered_integer_set_succ_pred.sv
